/* rtl/core/oaht_pkg.sv */
package oaht_pkg;

  localparam int SLOTS_DEF = 256;

  // slot marks
  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  // request types
  localparam logic [1:0] REQ_GET = 2'd0;
  localparam logic [1:0] REQ_SET = 2'd1;
  localparam logic [1:0] REQ_DEL = 2'd2;

  // result status
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_MISSING = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  // write enables into the slot store
  typedef struct packed {
    logic       mark_we;
    logic [1:0] mark;
    logic       key_we;
    logic       val_we;
  } store_wr_t;

endpackage

/* rtl/core/oaht_store.sv */
module oaht_store #(
  parameter int SLOTS = oaht_pkg::SLOTS_DEF,
  localparam int IdxW = $clog2(SLOTS)
) (
  input  logic                 clk,
  input  oaht_pkg::store_wr_t  wr,
  input  logic [IdxW-1:0]      wr_addr,
  input  logic [31:0]          wr_key,
  input  logic [63:0]          wr_val,
  input  logic [IdxW-1:0]      rd_addr,
  output logic [1:0]           rd_mark,
  output logic [31:0]          rd_key,
  output logic [63:0]          rd_val
);
  import oaht_pkg::*;

  logic [1:0]  mark_mem [SLOTS];
  logic [31:0] key_mem  [SLOTS];
  logic [63:0] val_mem  [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.mark_we) begin
      mark_mem[wr_addr] <= wr.mark;
    end
    if (wr.key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (wr.val_we) begin
      val_mem[wr_addr] <= wr_val;
    end
    rd_mark <= mark_mem[rd_addr];
    rd_key  <= key_mem[rd_addr];
    rd_val  <= val_mem[rd_addr];
  end

endmodule

/* rtl/core/open_addressing_hash_table_top.sv */
// Channel   Handshake          Payload
// request   start / busy       in_req_type, in_key_id, in_key_hash, in_value_in
// result    out_valid strobe   out_status, out_is_new_key, out_value_out
//
// A request is taken when start is high and busy is low. A get, set or
// delete request then walks the table one slot per cycle through a single
// read port, after 4-bit remainder steps over the hash when SLOTS is not a
// power of two. The result strobes in the cycle after the last probe, when
// busy is already low. After reset a clearing pass writes every slot mark
// with busy high. The receiver cannot stall.
module open_addressing_hash_table_top #(
  parameter int SLOTS = oaht_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_key_id,
  input  logic [31:0] in_key_hash,
  input  logic [63:0] in_value_in,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic        out_is_new_key,
  output logic [63:0] out_value_out
);
  import oaht_pkg::*;

  localparam int IdxW     = $clog2(SLOTS);
  localparam int RemW     = IdxW + 1;
  localparam int CntW     = $clog2(SLOTS + 1);
  localparam int LoadMax  = (3 * SLOTS) / 4;
  localparam bit IsPow2   = (SLOTS & (SLOTS - 1)) == 0;
  localparam int ModBits  = 4;
  localparam int ModSteps = 32 / ModBits;
  localparam int MstepW   = $clog2(ModSteps);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_MOD, S_PROBE} state_t;

  state_t            state_r, state_nxt;
  logic [IdxW-1:0]   idx_r, idx_nxt;
  logic [CntW-1:0]   n_r, n_nxt;
  logic [CntW-1:0]   used_r, used_nxt;
  logic [IdxW-1:0]   tomb_r, tomb_nxt;
  logic              have_tomb_r, have_tomb_nxt;
  logic [1:0]        req_r, req_nxt;
  logic [31:0]       key_r, key_nxt;
  logic [63:0]       val_r, val_nxt;
  logic [31:0]       hsh_r, hsh_nxt;
  logic [IdxW-1:0]   rem_r, rem_nxt;
  logic [MstepW-1:0] mstep_r, mstep_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic              out_new_r, out_new_nxt;
  logic [63:0]       out_value_r, out_value_nxt;

  store_wr_t         wr;
  logic [IdxW-1:0]   wr_addr;
  logic [1:0]        rd_mark;
  logic [31:0]       rd_key;
  logic [63:0]       rd_val;

  logic              is_empty, is_live, hit, is_tomb, last, have_now;
  logic [IdxW-1:0]   tomb_now, idx_inc, rem_step;

  function automatic logic [IdxW-1:0] mod_step(input logic [IdxW-1:0] rem,
                                               input logic [ModBits-1:0] bits);
    logic [RemW-1:0] r;
    r = {1'b0, rem};
    for (int i = ModBits - 1; i >= 0; i--) begin
      r = {r[IdxW-1:0], bits[i]};
      if (r >= RemW'(SLOTS)) begin
        r = r - RemW'(SLOTS);
      end
    end
    return r[IdxW-1:0];
  endfunction

  oaht_store #(.SLOTS(SLOTS)) u_store (
    .clk     (clk),
    .wr      (wr),
    .wr_addr (wr_addr),
    .wr_key  (key_r),
    .wr_val  (val_r),
    .rd_addr (idx_nxt),
    .rd_mark (rd_mark),
    .rd_key  (rd_key),
    .rd_val  (rd_val)
  );

  assign is_empty = rd_mark == MARK_EMPTY;
  assign is_live  = rd_mark == MARK_LIVE;
  assign hit      = is_live && (rd_key == key_r);
  assign is_tomb  = !is_empty && !is_live;
  assign last     = n_r == CntW'(SLOTS - 1);
  assign have_now = have_tomb_r || is_tomb;
  assign tomb_now = have_tomb_r ? tomb_r : idx_r;
  assign idx_inc  = (idx_r == IdxW'(SLOTS - 1)) ? '0 : idx_r + IdxW'(1);
  assign rem_step = mod_step(rem_r, hsh_r[31 -: ModBits]);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    used_nxt       = used_r;
    tomb_nxt       = tomb_r;
    have_tomb_nxt  = have_tomb_r;
    req_nxt        = req_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    hsh_nxt        = hsh_r;
    rem_nxt        = rem_r;
    mstep_nxt      = mstep_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_new_nxt    = out_new_r;
    out_value_nxt  = out_value_r;
    wr             = '0;
    wr_addr        = idx_r;

    case (state_r)
      S_CLEAR: begin
        wr.mark_we = 1'b1;
        wr.mark    = MARK_EMPTY;
        idx_nxt    = idx_inc;
        if (idx_r == IdxW'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt       = in_req_type;
          key_nxt       = in_key_id;
          val_nxt       = in_value_in;
          n_nxt         = '0;
          have_tomb_nxt = 1'b0;
          if (!(in_req_type inside {REQ_GET, REQ_SET, REQ_DEL})) begin
            // unused request code: answer at once
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_MISSING;
            out_new_nxt    = 1'b0;
            out_value_nxt  = '0;
          end else if (IsPow2) begin
            idx_nxt   = in_key_hash[IdxW-1:0];
            state_nxt = S_PROBE;
          end else begin
            hsh_nxt   = in_key_hash;
            rem_nxt   = '0;
            mstep_nxt = '0;
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        rem_nxt   = rem_step;
        hsh_nxt   = hsh_r << ModBits;
        mstep_nxt = mstep_r + MstepW'(1);
        if (mstep_r == MstepW'(ModSteps - 1)) begin
          idx_nxt   = rem_step;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!(is_empty || hit || last)) begin
          if (is_tomb && !have_tomb_r) begin
            tomb_nxt      = idx_r;
            have_tomb_nxt = 1'b1;
          end
          idx_nxt = idx_inc;
          n_nxt   = n_r + CntW'(1);
        end else begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_MISSING;
          out_new_nxt    = 1'b0;
          out_value_nxt  = '0;
          case (req_r)
            REQ_GET: begin
              if (hit) begin
                out_status_nxt = STAT_OK;
                out_value_nxt  = rd_val;
              end
            end
            REQ_DEL: begin
              if (hit) begin
                wr.mark_we     = 1'b1;
                wr.mark        = MARK_TOMB;
                out_status_nxt = STAT_OK;
              end
            end
            REQ_SET: begin
              if (hit) begin
                wr.val_we      = 1'b1;
                out_status_nxt = STAT_OK;
              end else if (have_now) begin
                // reuse first tombstone, count unchanged
                wr_addr        = tomb_now;
                wr.mark_we     = 1'b1;
                wr.mark        = MARK_LIVE;
                wr.key_we      = 1'b1;
                wr.val_we      = 1'b1;
                out_status_nxt = STAT_OK;
                out_new_nxt    = 1'b1;
              end else if (!is_empty || used_r >= CntW'(LoadMax)) begin
                out_status_nxt = STAT_FULL;
              end else begin
                wr.mark_we     = 1'b1;
                wr.mark        = MARK_LIVE;
                wr.key_we      = 1'b1;
                wr.val_we      = 1'b1;
                used_nxt       = used_r + CntW'(1);
                out_status_nxt = STAT_OK;
                out_new_nxt    = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      n_r         <= '0;
      used_r      <= '0;
      have_tomb_r <= 1'b0;
      mstep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      n_r         <= n_nxt;
      used_r      <= used_nxt;
      have_tomb_r <= have_tomb_nxt;
      mstep_r     <= mstep_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tomb_r       <= tomb_nxt;
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    hsh_r        <= hsh_nxt;
    rem_r        <= rem_nxt;
    out_status_r <= out_status_nxt;
    out_new_r    <= out_new_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign busy           = state_r != S_IDLE;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_is_new_key = out_new_r;
  assign out_value_out  = out_value_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_IDLE)
    else $error("result strobe outside idle");

  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted request neither answered nor in progress");

  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CntW'(LoadMax))
    else $error("used count above load limit");

  a_new_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_new_key) |-> (out_status == STAT_OK))
    else $error("new key reported without ok status");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |-> (out_value_out == '0))
    else $error("value returned on failed request");

endmodule
